### rtl/core/tvsa_pkg.sv
package tvsa_pkg;

	// Default geometry of the packet stream and the image.
	localparam int TVSA_WORDS_PER_PACKET    = 82;
	localparam int TVSA_PACKETS_PER_SEGMENT = 60;
	localparam int TVSA_IMAGE_WIDTH         = 160;
	localparam int TVSA_IMAGE_HEIGHT        = 120;
	localparam int TVSA_SEGMENT_COUNT       = 4;

	// Packet that carries the segment id, and the id limits.
	localparam int         TVSA_ID_PACKET     = 20;
	localparam logic [2:0] TVSA_ID_LAST       = 3'd4;
	localparam logic [3:0] TVSA_DISCARD_CODE  = 4'hF;
	localparam logic [3:0] TVSA_MASK_FULL     = 4'hF;

	// Command codes.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// One classified transaction as it waits in the queue.
	typedef struct packed {
		logic        is_read;
		logic        read_ok;
		logic        hdr_discard;
		logic [15:0] word;
		logic [7:0]  col;
		logic [6:0]  row;
	} tvsa_item_t;

endpackage

### rtl/core/tvsa_front.sv
module tvsa_front import tvsa_pkg::*; #(
	parameter int IMAGE_WIDTH  = TVSA_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = TVSA_IMAGE_HEIGHT
) (
	input  logic        command,
	input  logic [15:0] stream_word,
	input  logic [7:0]  read_column,
	input  logic [6:0]  read_row,
	output tvsa_item_t  item
);

	// Classify the transaction: read or push, read in range, discard header.
	always_comb begin
		item.is_read     = (command == CMD_READ);
		item.read_ok     = (int'(read_column) < IMAGE_WIDTH) &&
			(int'(read_row) < IMAGE_HEIGHT);
		item.hdr_discard = (stream_word[11:8] == TVSA_DISCARD_CODE);
		item.word        = stream_word;
		item.col         = read_column;
		item.row         = read_row;
	end

endmodule

### rtl/core/tvsa_queue.sv
module tvsa_queue import tvsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tvsa_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output tvsa_item_t head
);

	tvsa_item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	// Entry storage holds payload only.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### rtl/core/tvsa_back.sv
module tvsa_back import tvsa_pkg::*; #(
	parameter int WORDS_PER_PACKET    = TVSA_WORDS_PER_PACKET,
	parameter int PACKETS_PER_SEGMENT = TVSA_PACKETS_PER_SEGMENT,
	parameter int IMAGE_WIDTH         = TVSA_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT        = TVSA_IMAGE_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        q_not_empty,
	input  tvsa_item_t  q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_value,
	output logic        packet_dropped,
	output logic        segment_done,
	output logic [2:0]  segment_id,
	output logic        sync_error,
	output logic        frame_done,
	output logic [31:0] error_count,
	output logic [31:0] frame_count
);

	localparam int HALF_LINE = IMAGE_WIDTH / 2;
	localparam int ROWS_SEG  = PACKETS_PER_SEGMENT / 2;
	localparam int SEG_WORDS = PACKETS_PER_SEGMENT * HALF_LINE;
	localparam int IMG_WORDS = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int WP_W      = $clog2(WORDS_PER_PACKET);
	localparam int PI_W      = $clog2(PACKETS_PER_SEGMENT);
	localparam int PX_W      = (HALF_LINE > 1) ? $clog2(HALF_LINE) : 1;
	localparam int SA_W      = $clog2(SEG_WORDS);
	localparam int IA_W      = $clog2(IMG_WORDS);
	localparam int CR_W      = $clog2(2 * PACKETS_PER_SEGMENT + 2);
	localparam int RR_W      = $clog2(IMAGE_HEIGHT);
	localparam int CW_W      = $clog2(IMAGE_WIDTH);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_DRAIN
	} state_t;

	state_t state_q;

	// Stream tracking state.
	logic            rotate_q;
	logic [WP_W-1:0] wp_q;
	logic [PI_W-1:0] pi_q;
	logic            disc_q;
	logic            resync_q;
	logic [2:0]      capid_q;
	logic [3:0]      mask_q;
	logic [2:0]      seen_q;
	logic [31:0]     err_tot_q;
	logic [31:0]     frm_tot_q;

	// Memories.
	logic [15:0] seg_mem [SEG_WORDS];
	logic [15:0] img_mem [IMG_WORDS];
	logic [15:0] seg_rd_s1;
	logic [15:0] img_rd_q;
	logic        read_ok_q;

	// Clear and copy sequencing.
	logic [IA_W-1:0] clr_q;
	logic [PI_W-1:0] cp_p_q;
	logic [PX_W-1:0] cp_px_q;
	logic [SA_W-1:0] cp_src_q;
	logic [CR_W-1:0] cp_base_q;
	logic            cp_rot_q;
	logic            cp_we_s1;
	logic [IA_W-1:0] cp_dest_s1;

	// Output register.
	logic        out_valid_q;
	logic [15:0] pix_q;
	logic        drop_q;
	logic        done_q;
	logic [2:0]  sid_q;
	logic        serr_q;
	logic        fdone_q;

	logic            out_free;
	logic            out_load;
	logic            disc;
	logic            keep;
	logic            last_word;
	logic [PI_W:0]   pi_inc;
	logic            seg_end;
	logic            err_order;
	logic [2:0]      seen_inc;
	logic            seg_err;
	logic            seg_ok;
	logic [3:0]      new_mask;
	logic            frame_end;
	logic            seg_we;
	logic [SA_W-1:0] seg_wa;
	logic [IA_W-1:0] rd_addr;
	logic [CR_W-1:0] cp_row;
	logic [CW_W-1:0] cp_col;
	logic [RR_W-1:0] dst_row;
	logic [CW_W-1:0] dst_col;
	logic            cp_row_ok;
	logic [IA_W-1:0] cp_dest;
	logic            cp_last;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == ST_IDLE) && q_not_empty && out_free;

	// A result is loaded by a popped push or by a read leaving the read state.
	assign out_load = (q_pop && !q_head.is_read) || ((state_q == ST_READ) && out_free);

	// Packet and segment classification for a pushed word.
	always_comb begin
		disc      = (wp_q == '0) ? q_head.hdr_discard : disc_q;
		keep      = !disc && !resync_q;
		last_word = (wp_q == WP_W'(WORDS_PER_PACKET - 1));
		pi_inc    = {1'b0, pi_q} + (PI_W+1)'(1);
		seg_end   = (pi_inc == (PI_W+1)'(PACKETS_PER_SEGMENT));
		err_order = ((capid_q == 3'd2) && !mask_q[0]) ||
			((capid_q == 3'd3) && (mask_q[1:0] == 2'b00)) ||
			((capid_q == 3'd4) && (mask_q[2:0] == 3'b000));
		seen_inc  = seen_q + 3'd1;
		seg_err   = (capid_q != 3'd0) && (err_order ||
			(int'(seen_inc) > TVSA_SEGMENT_COUNT) || (capid_q > TVSA_ID_LAST));
		seg_ok    = (capid_q != 3'd0) && !seg_err;
		new_mask  = mask_q | (4'b0001 << (capid_q - 3'd1));
		frame_end = seg_err || (seg_ok && (new_mask == TVSA_MASK_FULL));
		seg_we    = q_pop && !q_head.is_read && keep && (wp_q >= WP_W'(2)) &&
			((int'(wp_q) - 2) < HALF_LINE);
		seg_wa    = SA_W'(pi_q) * SA_W'(HALF_LINE) + SA_W'(wp_q - WP_W'(2));
		rd_addr   = IA_W'(q_head.row) * IA_W'(IMAGE_WIDTH) + IA_W'(q_head.col);
	end

	// Destination of the current copy word.
	always_comb begin
		cp_row    = cp_base_q + CR_W'(cp_p_q >> 1);
		cp_col    = cp_p_q[0] ? CW_W'(HALF_LINE) + CW_W'(cp_px_q) : CW_W'(cp_px_q);
		cp_row_ok = (int'(cp_row) < IMAGE_HEIGHT);
		dst_row   = cp_rot_q ? RR_W'(IMAGE_HEIGHT - 1) - RR_W'(cp_row) : RR_W'(cp_row);
		dst_col   = cp_rot_q ? CW_W'(IMAGE_WIDTH - 1) - cp_col : cp_col;
		cp_dest   = IA_W'(dst_row) * IA_W'(IMAGE_WIDTH) + IA_W'(dst_col);
		cp_last   = (cp_p_q == PI_W'(PACKETS_PER_SEGMENT - 1)) &&
			(cp_px_q == PX_W'(HALF_LINE - 1));
	end

	// Segment buffer: written by kept words, read by the copy sequencer.
	always_ff @(posedge clk) begin
		if (seg_we) begin
			seg_mem[seg_wa] <= q_head.word;
		end
		if (state_q == ST_COPY) begin
			seg_rd_s1 <= seg_mem[cp_src_q];
		end
	end

	// Image: cleared after reset, filled by copies, read by command.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			img_mem[clr_q] <= 16'd0;
		end else if (cp_we_s1) begin
			img_mem[cp_dest_s1] <= seg_rd_s1;
		end
		if (q_pop && q_head.is_read && q_head.read_ok) begin
			img_rd_q <= img_mem[rd_addr];
		end
	end

	// Control sequencer, stream state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rotate_q    <= 1'b0;
			wp_q        <= '0;
			pi_q        <= '0;
			disc_q      <= 1'b0;
			resync_q    <= 1'b0;
			capid_q     <= 3'd0;
			mask_q      <= 4'd0;
			seen_q      <= 3'd0;
			err_tot_q   <= 32'd0;
			frm_tot_q   <= 32'd0;
			clr_q       <= '0;
			cp_we_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) rotate_q <= cfg_write_data;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			cp_we_s1 <= (state_q == ST_COPY) && cp_row_ok;

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IA_W'(1);
					if (clr_q == IA_W'(IMG_WORDS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_pop && q_head.is_read) begin
						read_ok_q <= q_head.read_ok;
						state_q   <= ST_READ;
					end else if (q_pop) begin
						pix_q       <= 16'd0;
						drop_q      <= 1'b0;
						done_q      <= 1'b0;
						sid_q       <= 3'd0;
						serr_q      <= 1'b0;
						fdone_q     <= 1'b0;
						if (wp_q == '0) disc_q <= q_head.hdr_discard;
						if (keep && (wp_q == '0) &&
							(pi_q == PI_W'(TVSA_ID_PACKET))) begin
							capid_q <= q_head.word[14:12];
						end
						if (!last_word) begin
							wp_q <= wp_q + WP_W'(1);
						end else begin
							wp_q <= '0;
							if (disc) begin
								drop_q <= 1'b1;
							end else if (resync_q) begin
								resync_q <= 1'b0;
								drop_q   <= 1'b1;
							end else if (!seg_end) begin
								pi_q <= pi_inc[PI_W-1:0];
							end else begin
								pi_q  <= '0;
								sid_q <= capid_q;
								if (seg_err) begin
									serr_q    <= 1'b1;
									fdone_q   <= 1'b1;
									resync_q  <= 1'b1;
									mask_q    <= 4'd0;
									seen_q    <= 3'd0;
									err_tot_q <= err_tot_q + 32'd1;
									frm_tot_q <= frm_tot_q + 32'd1;
								end else if (seg_ok) begin
									done_q    <= 1'b1;
									cp_base_q <= CR_W'(capid_q - 3'd1) * CR_W'(ROWS_SEG);
									cp_rot_q  <= rotate_q;
									cp_p_q    <= '0;
									cp_px_q   <= '0;
									cp_src_q  <= '0;
									state_q   <= ST_COPY;
									if (frame_end) begin
										fdone_q   <= 1'b1;
										mask_q    <= 4'd0;
										seen_q    <= 3'd0;
										frm_tot_q <= frm_tot_q + 32'd1;
									end else begin
										mask_q <= new_mask;
										seen_q <= seen_inc;
									end
								end
							end
						end
					end
				end
				ST_READ: begin
					if (out_free) begin
						pix_q       <= read_ok_q ? img_rd_q : 16'd0;
						drop_q      <= 1'b0;
						done_q      <= 1'b0;
						sid_q       <= 3'd0;
						serr_q      <= 1'b0;
						fdone_q     <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_COPY: begin
					cp_dest_s1 <= cp_dest;
					cp_src_q   <= cp_src_q + SA_W'(1);
					if (cp_px_q == PX_W'(HALF_LINE - 1)) begin
						cp_px_q <= '0;
						cp_p_q  <= cp_p_q + PI_W'(1);
					end else begin
						cp_px_q <= cp_px_q + PX_W'(1);
					end
					if (cp_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_value    = pix_q;
	assign packet_dropped = drop_q;
	assign segment_done   = done_q;
	assign segment_id     = sid_q;
	assign sync_error     = serr_q;
	assign frame_done     = fdone_q;
	assign error_count    = err_tot_q;
	assign frame_count    = frm_tot_q;

`ifndef SYNTHESIS
	// The frame state never rests with all four segments collected.
	assert property (@(posedge clk) disable iff (!arst_n) mask_q != TVSA_MASK_FULL)
		else $error("collected mask left full");

	// No more than four segments counted in one attempt.
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(seen_q) <= TVSA_SEGMENT_COUNT)
		else $error("segment count overflow");

	// Counters do not move while a segment is being copied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |=> ($stable(err_tot_q) && $stable(frm_tot_q)))
		else $error("counters changed during copy");

	// A popped read always goes through the read state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.is_read) |=> (state_q == ST_READ))
		else $error("read did not enter read state");
`endif

endmodule

### rtl/core/thermal_video_segment_assembler.sv
// Pushes run in the back end's idle state; reads also pass a read state (registered image port).
// Push results are registered at the pop; read results first pass the image read register.
// An accepted segment stalls the back end while the segment buffer is copied
// into the image, one word a cycle.
// After reset the image is cleared word by word; transactions are queued but not executed
// until then, configuration writes are taken at once.
module thermal_video_segment_assembler import tvsa_pkg::*; #(
	parameter int WORDS_PER_PACKET    = TVSA_WORDS_PER_PACKET,
	parameter int PACKETS_PER_SEGMENT = TVSA_PACKETS_PER_SEGMENT,
	parameter int IMAGE_WIDTH         = TVSA_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT        = TVSA_IMAGE_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [15:0] stream_word,
	input  logic [7:0]  read_column,
	input  logic [6:0]  read_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_value,
	output logic        packet_dropped,
	output logic        segment_done,
	output logic [2:0]  segment_id,
	output logic        sync_error,
	output logic        frame_done,
	output logic [31:0] error_count,
	output logic [31:0] frame_count
);

	tvsa_item_t item;
	tvsa_item_t head;
	logic       q_full;
	logic       q_not_empty;
	logic       q_pop;

	// Classify incoming transactions.
	tvsa_front #(
		.IMAGE_WIDTH (IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT)
	) u_front (
		.command    (command),
		.stream_word(stream_word),
		.read_column(read_column),
		.read_row   (read_row),
		.item       (item)
	);

	// Short queue between intake and execution.
	assign in_stall = q_full;

	tvsa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && !q_full),
		.push_item(item),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (head)
	);

	// Execution: stream tracking, buffers, copy and read-back.
	tvsa_back #(
		.WORDS_PER_PACKET   (WORDS_PER_PACKET),
		.PACKETS_PER_SEGMENT(PACKETS_PER_SEGMENT),
		.IMAGE_WIDTH        (IMAGE_WIDTH),
		.IMAGE_HEIGHT       (IMAGE_HEIGHT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.q_not_empty   (q_not_empty),
		.q_head        (head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_value   (pixel_value),
		.packet_dropped(packet_dropped),
		.segment_done  (segment_done),
		.segment_id    (segment_id),
		.sync_error    (sync_error),
		.frame_done    (frame_done),
		.error_count   (error_count),
		.frame_count   (frame_count)
	);

endmodule

### test/tb_thermal_video_segment_assembler.sv
`timescale 1ns / 1ps

module tb_thermal_video_segment_assembler;
	import tvsa_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int HALF_LINE   = TVSA_IMAGE_WIDTH / 2;
	localparam int SEG_WORDS   = TVSA_PACKETS_PER_SEGMENT * HALF_LINE;
	localparam int IMG_WORDS   = TVSA_IMAGE_WIDTH * TVSA_IMAGE_HEIGHT;
	localparam int WATCHDOG    = 60000;
	localparam int SETTLE      = 6000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic [15:0] pixel;
		logic        dropped;
		logic        seg_done;
		logic [2:0]  sid;
		logic        serr;
		logic        fdone;
		logic [31:0] errs;
		logic [31:0] frames;
	} result_t;

	typedef struct {
		logic        cmd;
		logic [15:0] word;
		logic [7:0]  col;
		logic [6:0]  row;
		bit          typed;
		result_t     want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic        cfg_write_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = CMD_PUSH;
	logic [15:0] stream_word = '0;
	logic [7:0]  read_column = '0;
	logic [6:0]  read_row = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] pixel_value;
	logic        packet_dropped;
	logic        segment_done;
	logic [2:0]  segment_id;
	logic        sync_error;
	logic        frame_done;
	logic [31:0] error_count;
	logic [31:0] frame_count;

	thermal_video_segment_assembler uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .stream_word(stream_word),
		.read_column(read_column), .read_row(read_row),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_value(pixel_value), .packet_dropped(packet_dropped),
		.segment_done(segment_done), .segment_id(segment_id),
		.sync_error(sync_error), .frame_done(frame_done),
		.error_count(error_count), .frame_count(frame_count)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Shadow copy of the assembler state.
	logic [6:0]  sh_word_pos;
	logic [5:0]  sh_packet;
	bit          sh_discard;
	bit          sh_resync;
	logic [2:0]  sh_captured_id;
	logic [3:0]  sh_mask;
	logic [2:0]  sh_seen;
	logic [15:0] sh_segment [SEG_WORDS];
	logic [15:0] sh_image [IMG_WORDS];
	logic [31:0] sh_errors;
	logic [31:0] sh_frames;
	bit          sh_rotate;
	int          packets_closed;
	int          packets_dropped;
	int          segments_closed;
	int          segments_copied;

	result_t     pending_results [$];
	int          mismatches;
	int          items_sent;
	int          accept_count;
	bit          idle_mode;
	bit          hold_request;

	// Compute the result of one transaction and advance the shadow state.
	function automatic result_t assemble(logic cmd, logic [15:0] w, logic [7:0] c,
			logic [6:0] r);
		result_t res;
		bit keep, err;
		int row, col, rr, cc;
		res = '0;
		if (cmd == CMD_READ) begin
			if (c < TVSA_IMAGE_WIDTH && r < TVSA_IMAGE_HEIGHT)
				res.pixel = sh_image[r * TVSA_IMAGE_WIDTH + c];
		end else begin
			if (sh_word_pos == 0)
				sh_discard = (w[11:8] == TVSA_DISCARD_CODE);
			keep = !sh_discard && !sh_resync;
			if (keep && sh_word_pos == 0 && sh_packet == TVSA_ID_PACKET)
				sh_captured_id = w[14:12];
			if (keep && sh_word_pos >= 2 && sh_word_pos - 2 < HALF_LINE)
				sh_segment[sh_packet * HALF_LINE + sh_word_pos - 2] = w;
			if (sh_word_pos >= TVSA_WORDS_PER_PACKET - 1) begin
				sh_word_pos = 0;
				packets_closed++;
				if (sh_discard) begin
					res.dropped = 1'b1;
					packets_dropped++;
				end else if (sh_resync) begin
					sh_resync = 0;
					res.dropped = 1'b1;
					packets_dropped++;
				end else begin
					sh_packet++;
					if (sh_packet >= TVSA_PACKETS_PER_SEGMENT) begin
						sh_packet = 0;
						segments_closed++;
						res.sid = sh_captured_id;
						if (res.sid != 0) begin
							err = (res.sid == 2 && !sh_mask[0]) ||
								(res.sid == 3 && sh_mask[1:0] == 0) ||
								(res.sid == 4 && sh_mask[2:0] == 0);
							if (!err) begin
								sh_seen++;
								if (sh_seen > TVSA_SEGMENT_COUNT || res.sid > TVSA_ID_LAST)
									err = 1;
							end
							if (err) begin
								// Bad order, id or segment count: count it, end the attempt, resync.
								sh_errors++;
								sh_resync = 1;
								sh_mask = 0;
								sh_seen = 0;
								sh_frames++;
								res.serr = 1'b1;
								res.fdone = 1'b1;
							end else begin
								sh_mask[res.sid - 1] = 1'b1;
								segments_copied++;
								for (int p = 0; p < TVSA_PACKETS_PER_SEGMENT; p++) begin
									row = (res.sid - 1) * (TVSA_PACKETS_PER_SEGMENT / 2) + p / 2;
									if (row >= TVSA_IMAGE_HEIGHT)
										continue;
									for (int x = 0; x < HALF_LINE; x++) begin
										col = (p % 2) ? HALF_LINE + x : x;
										rr = sh_rotate ? TVSA_IMAGE_HEIGHT - 1 - row : row;
										cc = sh_rotate ? TVSA_IMAGE_WIDTH - 1 - col : col;
										sh_image[rr * TVSA_IMAGE_WIDTH + cc] =
											sh_segment[p * HALF_LINE + x];
									end
								end
								res.seg_done = 1'b1;
								if (sh_mask == TVSA_MASK_FULL) begin
									sh_mask = 0;
									sh_seen = 0;
									sh_frames++;
									res.fdone = 1'b1;
								end
							end
						end
					end
				end
			end else begin
				sh_word_pos++;
			end
		end
		res.errs = sh_errors;
		res.frames = sh_frames;
		return res;
	endfunction

	// Offer one transaction, wait for acceptance, then record its expected result.
	task automatic send(logic cmd, logic [15:0] w, logic [7:0] c, logic [6:0] r,
			bit typed = 0, result_t want = '0);
		int gap;
		bit stalled;
		result_t res;
		if (items_sent % 300 == 0)
			idle_mode = ($urandom_range(0, 9) < 3);
		gap = idle_mode ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		command = cmd;
		stream_word = w;
		read_column = c;
		read_row = r;
		stalled = 1;
		while (stalled) begin
			#(HALF_PERIOD - 1);
			stalled = in_stall;
			@(posedge clk);
			if (stalled)
				@(negedge clk);
		end
		res = assemble(cmd, w, c, r);
		pending_results.push_back(typed ? want : res);
		items_sent++;
		accept_count++;
		@(negedge clk);
	endtask

	task automatic read_random();
		if ($urandom_range(0, 7) == 0)
			send(CMD_READ, 16'($urandom), 8'($urandom), 7'($urandom));
		else
			send(CMD_READ, 16'($urandom), 8'($urandom_range(0, TVSA_IMAGE_WIDTH - 1)),
				7'($urandom_range(0, TVSA_IMAGE_HEIGHT - 1)));
	endtask

	// One packet, discard or kept; the id goes into the header of the id packet.
	task automatic send_packet(bit discard, logic [2:0] id);
		logic [15:0] w;
		w = 16'($urandom);
		if (discard)
			w[11:8] = TVSA_DISCARD_CODE;
		else if (w[11:8] == TVSA_DISCARD_CODE)
			w[11:8] = 4'($urandom_range(0, 14));
		if (!discard && sh_packet == TVSA_ID_PACKET)
			w[14:12] = id;
		send(CMD_PUSH, w, '0, '0);
		for (int i = 1; i < TVSA_WORDS_PER_PACKET; i++) begin
			if ($urandom_range(0, 39) == 0)
				read_random();
			send(CMD_PUSH, 16'($urandom), 8'($urandom), 7'($urandom));
		end
	endtask

	// Fill up the current partial packet so the next word starts a header.
	task automatic finish_packet();
		while (sh_word_pos != 0)
			send(CMD_PUSH, 16'($urandom), '0, '0);
	endtask

	task automatic read_sweep(int count);
		send(CMD_READ, '0, '0, '0);
		send(CMD_READ, '0, 8'(TVSA_IMAGE_WIDTH - 1), 7'(TVSA_IMAGE_HEIGHT - 1));
		send(CMD_READ, '0, 8'(TVSA_IMAGE_WIDTH - 1), '0);
		send(CMD_READ, '0, '0, 7'(TVSA_IMAGE_HEIGHT - 1));
		repeat (count) read_random();
	endtask

	// Let everything drain, then give the back end time to finish any copy.
	task automatic drain();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_rotate(bit value);
		cfg_write_en = 1'b1;
		cfg_write_data = value;
		@(negedge clk);
		cfg_write_en = 1'b0;
		sh_rotate = value;
	endtask

	// Receiver: random stalls, one long hold-off on request, and the checks.
	int stall_left = 0;
	int hold_left = 0;
	initial begin
		result_t got, want;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
			#(HALF_PERIOD - 1);
			if (arst_n && out_valid && !out_stall) begin
				accept_count++;
				got = '{pixel_value, packet_dropped, segment_done, segment_id,
					sync_error, frame_done, error_count, frame_count};
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected transaction on the output: %p", got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch at %0t: expected %p, got %p", $realtime, want, got);
					end
				end
				stall_left = idle_mode ? $urandom_range(0, 13) : 0;
			end
		end
	end

	// Watchdog on cycles without any accepted transaction.
	initial begin
		int last_count, quiet;
		last_count = 0;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (accept_count != last_count) begin
				last_count = accept_count;
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= WATCHDOG) begin
					$display("Timeout: no transaction for %0d cycles", WATCHDOG);
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	// Directed rows, then random packet streams mixed with reads.
	stim_row_t directed [$];
	initial begin
		stim_row_t row;
		result_t zero;
		zero = '0;
		sh_word_pos = 0;
		sh_packet = 0;
		sh_discard = 0;
		sh_resync = 0;
		sh_captured_id = 0;
		sh_mask = 0;
		sh_seen = 0;
		sh_errors = 0;
		sh_frames = 0;
		sh_rotate = 0;
		foreach (sh_image[i])
			sh_image[i] = '0;
		foreach (sh_segment[i])
			sh_segment[i] = '0;
		mismatches = 0;
		items_sent = 0;
		accept_count = 0;
		idle_mode = 0;
		hold_request = 0;
		packets_closed = 0;
		packets_dropped = 0;
		segments_closed = 0;
		segments_copied = 0;

		// Reads of a cleared image at corners and beyond its edges.
		directed.push_back('{CMD_READ, 16'hFFFF, 8'd0, 7'd0, 1, zero});
		directed.push_back('{CMD_READ, 16'h0000, 8'd159, 7'd119, 1, zero});
		directed.push_back('{CMD_READ, 16'h0000, 8'd160, 7'd0, 1, zero});
		directed.push_back('{CMD_READ, 16'h0000, 8'd0, 7'd120, 1, zero});
		directed.push_back('{CMD_READ, 16'hFFFF, 8'd255, 7'd127, 1, zero});
		directed.push_back('{CMD_READ, 16'h0000, 8'd159, 7'd0, 1, zero});
		directed.push_back('{CMD_READ, 16'h0000, 8'd0, 7'd119, 1, zero});
		// A discard header and extreme words, nothing completes yet.
		directed.push_back('{CMD_PUSH, 16'h0F00, 8'd0, 7'd0, 1, zero});
		directed.push_back('{CMD_PUSH, 16'hFFFF, 8'd255, 7'd127, 1, zero});
		directed.push_back('{CMD_PUSH, 16'h0000, 8'd0, 7'd0, 1, zero});
		directed.push_back('{CMD_PUSH, 16'h8000, 8'd0, 7'd0, 0, zero});
		directed.push_back('{CMD_PUSH, 16'h7FFF, 8'd0, 7'd0, 0, zero});
		directed.push_back('{CMD_READ, 16'hFFFF, 8'd80, 7'd60, 1, zero});
		directed.push_back('{CMD_PUSH, 16'hAAAA, 8'd0, 7'd0, 0, zero});
		directed.push_back('{CMD_PUSH, 16'h5555, 8'd0, 7'd0, 0, zero});

		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		write_rotate(1);
		write_rotate(0);

		foreach (directed[i]) begin
			row = directed[i];
			send(row.cmd, row.word, row.col, row.row, row.typed, row.want);
		end

		// Close the discard packet, then kept and discard packets with reads.
		finish_packet();
		for (int i = 0; i < 6; i++)
			send_packet(i % 3 == 1, 3'($urandom_range(1, 4)));
		read_sweep(40);
		drain();

		// Rotation on, the receiver holding off while packets keep streaming in.
		write_rotate(1);
		hold_request = 1;
		for (int i = 0; i < 6; i++)
			send_packet($urandom_range(0, 2) == 0, 3'($urandom_range(1, 4)));
		read_sweep(40);
		drain();

		// Upright again: raw words and reads in random order.
		write_rotate(0);
		repeat (320) begin
			if ($urandom_range(0, 4) == 0)
				read_random();
			else
				send(CMD_PUSH, 16'($urandom), '0, '0);
		end
		read_sweep(40);

		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("Sent %0d transactions: %0d packets completed, %0d of them dropped.",
			items_sent, packets_closed, packets_dropped);
		$display("Image reads across a cleared image, long output hold-off, mismatches %0d.",
			mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
